>>> hw/rtl/bilinear_image_rotate_defines.svh
// ---------------------------------------------------------------------------
// Bilinear image rotate assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_ROTATE_DEFINES_SVH
`define BILINEAR_IMAGE_ROTATE_DEFINES_SVH

`ifndef SYNTH
`define BIR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BIR_ASSERT_IMPL(label, ante, cons)
`define BIR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/bir_pkg.sv
// ---------------------------------------------------------------------------
// Bilinear image rotate package
// Sizes, operation codes, register indexes and pipeline types.
// ---------------------------------------------------------------------------
`default_nettype none
package bir_pkg;
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRACTION_BITS = 8;
    localparam int POS_BITS      = 15;
    localparam int XW            = $clog2(MAX_WIDTH);
    localparam int YW            = $clog2(MAX_HEIGHT);
    localparam int DW            = $clog2(MAX_WIDTH) + 1;
    localparam int HW            = $clog2(MAX_HEIGHT) + 1;
    localparam int BANK_DEPTH    = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int BANK_AW       = $clog2(BANK_DEPTH);
    localparam int PAW           = 3;

    typedef enum logic { OP_LOAD = 1'b0, OP_FETCH = 1'b1 } op_t;

    typedef enum logic [PAW-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_SINE   = 3'd2,
        REG_COSINE = 3'd3,
        REG_BACKGR = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [DW-1:0]      w;
        logic [HW-1:0]      h;
        logic signed [15:0] s;
        logic signed [15:0] c;
        logic [7:0]         bg;
    } cfg_t;

    // per-fetch sideband carried alongside the frame reads
    typedef struct packed {
        logic                     valid;
        logic                     bg;
        logic                     copy;
        logic [1:0]               sel;
        logic [FRACTION_BITS-1:0] fx;
        logic [FRACTION_BITS-1:0] fy;
    } fetch_t;
endpackage
`default_nettype wire

>>> hw/rtl/bir_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module bir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/bir_map.sv
// ---------------------------------------------------------------------------
// Bilinear image rotate coordinate mapper
// Two-stage inverse mapping of an output pixel to a source point.
// ---------------------------------------------------------------------------
`default_nettype none
module bir_map (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fetch,
    input  wire logic [bir_pkg::XW-1:0]  x,
    input  wire logic [bir_pkg::YW-1:0]  y,
    input  wire bir_pkg::cfg_t           cfg,
    output bir_pkg::fetch_t              info,
    output logic [bir_pkg::XW-1:0]       x0,
    output logic [bir_pkg::YW-1:0]       y0
);
    import bir_pkg::*;

    localparam int PW = 36;

    logic                     v1_reg, bg1_reg, copy1_reg;
    logic signed [PW-1:0]     sx_base_reg, sy_base_reg;
    logic signed [PW-1:0]     uc_reg, vs_reg, us_reg, vc_reg;
    logic [XW-1:0]            xc_reg;
    logic [YW-1:0]            yc_reg;
    logic signed [DW+1:0]     u2, v2;
    logic signed [PW-1:0]     sx, sy;
    logic signed [PW-POS_BITS-1:0] xw, yw;
    logic                     outside;
    fetch_t                   info_reg, info_next;
    logic [XW-1:0]            x0_reg, x0_next;
    logic [YW-1:0]            y0_reg, y0_next;

    assign u2 = $signed({2'b00, x, 1'b0}) - $signed({2'b00, cfg.w}) + (DW+2)'(1);
    assign v2 = $signed({2'b00, y, 1'b0}) - $signed({2'b00, cfg.h}) + (DW+2)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            info_reg <= '0;
        end
        else
        begin
            v1_reg   <= fetch;
            info_reg <= info_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bg1_reg     <= ({1'b0, x} >= cfg.w) || ({1'b0, y} >= cfg.h);
        copy1_reg   <= (cfg.s == 16'sd0) && (cfg.c == 16'sd16384);
        uc_reg      <= PW'(u2 * cfg.c);
        vs_reg      <= PW'(v2 * cfg.s);
        us_reg      <= PW'(u2 * cfg.s);
        vc_reg      <= PW'(v2 * cfg.c);
        sx_base_reg <= $signed({{(PW-DW-14){1'b0}}, cfg.w - 1'b1, 14'd0});
        sy_base_reg <= $signed({{(PW-HW-14){1'b0}}, cfg.h - 1'b1, 14'd0});
        xc_reg      <= x;
        yc_reg      <= y;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
    end

    assign sx = sx_base_reg + uc_reg - vs_reg;
    assign sy = sy_base_reg + us_reg + vc_reg;
    assign xw = sx[PW-1:POS_BITS];
    assign yw = sy[PW-1:POS_BITS];
    assign outside = xw[PW-POS_BITS-1] || yw[PW-POS_BITS-1]
        || (xw + 1 >= $signed({{(PW-POS_BITS-DW){1'b0}}, cfg.w}))
        || (yw + 1 >= $signed({{(PW-POS_BITS-HW){1'b0}}, cfg.h}));

    always_comb
    begin
        info_next.valid = v1_reg;
        info_next.copy  = copy1_reg;
        info_next.bg    = bg1_reg || (!copy1_reg && outside);
        info_next.fx    = sx[POS_BITS-1 -: FRACTION_BITS];
        info_next.fy    = sy[POS_BITS-1 -: FRACTION_BITS];
        info_next.sel   = copy1_reg ? {yc_reg[0], xc_reg[0]} : {yw[0], xw[0]};
        x0_next         = copy1_reg ? xc_reg : xw[XW-1:0];
        y0_next         = copy1_reg ? yc_reg : yw[YW-1:0];
    end

    assign info = info_reg;
    assign x0   = x0_reg;
    assign y0   = y0_reg;
endmodule
`default_nettype wire

>>> hw/rtl/bir_blend.sv
// ---------------------------------------------------------------------------
// Bilinear image rotate blender
// Two-stage per-channel bilinear blend with rounding and clamp.
// ---------------------------------------------------------------------------
`default_nettype none
module bir_blend (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bir_pkg::fetch_t       info,
    input  wire logic [31:0]           p00,
    input  wire logic [31:0]           p01,
    input  wire logic [31:0]           p10,
    input  wire logic [31:0]           p11,
    input  wire logic [7:0]            bg_level,
    output logic                       strobe,
    output logic [31:0]                pixel,
    output logic                       is_bg
);
    import bir_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int TW = 8 + F + 1;
    localparam int VW = 8 + 2 * F + 2;

    logic [TW-1:0]  top_reg [4];
    logic [TW-1:0]  bot_reg [4];
    logic [F:0]     fy_reg;
    logic [31:0]    copy_reg;
    fetch_t         i_reg;
    logic           strobe_reg;
    logic [31:0]    pixel_reg, pixel_next;
    logic           is_bg_reg;
    logic [F:0]     wx0, wx1;

    assign wx1 = {1'b0, info.fx};
    assign wx0 = (F+1)'(1 << F) - wx1;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            top_reg[k] <= TW'(p00[8*k +: 8] * wx0 + p01[8*k +: 8] * wx1);
            bot_reg[k] <= TW'(p10[8*k +: 8] * wx0 + p11[8*k +: 8] * wx1);
        end
        fy_reg    <= {1'b0, info.fy};
        copy_reg  <= p00;
        pixel_reg <= pixel_next;
        is_bg_reg <= i_reg.bg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            i_reg      <= info;
            strobe_reg <= i_reg.valid;
        end
    end

    always_comb
    begin
        logic [F:0]    wy0;
        logic [VW-1:0] val;
        wy0 = (F+1)'(1 << F) - fy_reg;
        pixel_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            val = VW'(top_reg[k] * wy0) + VW'(bot_reg[k] * fy_reg)
                + VW'(1 << (2 * F - 1));
            val = val >> (2 * F);
            pixel_next[8*k +: 8] = (val > VW'(255)) ? 8'hFF : val[7:0];
        end
        if (i_reg.bg)
        begin
            pixel_next = {8'hFF, bg_level, bg_level, bg_level};
        end
        else if (i_reg.copy)
        begin
            pixel_next = copy_reg;
        end
    end

    assign strobe = strobe_reg;
    assign pixel  = pixel_reg;
    assign is_bg  = is_bg_reg;
endmodule
`default_nettype wire

>>> hw/rtl/bilinear_image_rotate.sv
// ---------------------------------------------------------------------------
// Bilinear image rotate
// Frame store with inverse-mapped bilinear rotation of BGRA pixels.
// ---------------------------------------------------------------------------
// Usage: an item is taken when start is high; busy is always low, so one
// item per clock. operation 0 loads source_pixel at (column,row_index);
// operation 1 fetches the rotated output pixel at (column,row_index).
// A fetch gives one result on rotated_pixel/is_background marked by done;
// loads give none. Throughput one item a cycle, set by the four-bank
// frame store (one bank per 2x2 neighbour parity, read once each per
// fetch). Loads and fetches are kept in order: a load is written after
// passing the load delay registers (ld_v_reg), when a fetch issued earlier
// has already read the banks, and a fetch issued later reads after it.
// Registers via APB: width, height, sine, cosine, background at 4*i.
// Configure only when idle. Reset clears control state; the frame store
// holds no reset value and must be loaded before use. done cannot be
// stalled by the receiver.
`default_nettype none
`include "bilinear_image_rotate_defines.svh"
module bilinear_image_rotate (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [4:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      operation,
    input  wire logic [7:0]                column,
    input  wire logic [7:0]                row_index,
    input  wire logic [31:0]               source_pixel,
    output logic                           done,
    output logic [31:0]                    rotated_pixel,
    output logic                           is_background
);
    import bir_pkg::*;

    logic [8:0]         wid_reg, hgt_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic [7:0]         bgl_reg;
    cfg_t               cfg;
    reg_idx_t           widx;
    logic               wr;
    logic               accept, fetch;
    fetch_t             info;
    logic [XW-1:0]      x0;
    logic [YW-1:0]      y0;
    logic [XW-1:0]      ld_x_reg [2];
    logic [YW-1:0]      ld_y_reg [2];
    logic [31:0]        ld_d_reg [2];
    logic [1:0]         ld_v_reg;
    logic [31:0]        rd [4];
    logic [1:0]         sel_reg;
    fetch_t             info_reg;
    logic [31:0]        q00, q01, q10, q11;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_reg <= 9'd256;
            hgt_reg <= 9'd256;
            sin_reg <= 16'sd0;
            cos_reg <= 16'sd16384;
            bgl_reg <= 8'd255;
        end
        else if (wr)
        begin
            case (widx)
                REG_WIDTH:  wid_reg <= pwdata[8:0];
                REG_HEIGHT: hgt_reg <= pwdata[8:0];
                REG_SINE:   sin_reg <= pwdata[15:0];
                REG_COSINE: cos_reg <= pwdata[15:0];
                REG_BACKGR: bgl_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_WIDTH:  prdata = {23'd0, wid_reg};
            REG_HEIGHT: prdata = {23'd0, hgt_reg};
            REG_SINE:   prdata = {{16{sin_reg[15]}}, sin_reg};
            REG_COSINE: prdata = {{16{cos_reg[15]}}, cos_reg};
            REG_BACKGR: prdata = {24'd0, bgl_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.w  = (wid_reg == '0) ? DW'(1) : (wid_reg > DW'(MAX_WIDTH) ? DW'(MAX_WIDTH)
                 : DW'(wid_reg));
        cfg.h  = (hgt_reg == '0) ? HW'(1) : (hgt_reg > HW'(MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                 : HW'(hgt_reg));
        cfg.s  = sin_reg;
        cfg.c  = cos_reg;
        cfg.bg = bgl_reg;
    end

    assign accept = start && !busy;
    assign fetch  = accept && (operation == OP_FETCH);

    // loads delayed through the ld_v_reg/ld_*_reg registers to line up with the mapper's bank reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_v_reg <= '0;
        end
        else
        begin
            ld_v_reg <= {ld_v_reg[0], accept && (operation == OP_LOAD)};
        end
    end

    always_ff @(posedge clk)
    begin
        ld_x_reg[0] <= column;
        ld_y_reg[0] <= row_index;
        ld_d_reg[0] <= source_pixel;
        ld_x_reg[1] <= ld_x_reg[0];
        ld_y_reg[1] <= ld_y_reg[0];
        ld_d_reg[1] <= ld_d_reg[0];
        sel_reg     <= info.sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg <= '0;
        end
        else
        begin
            info_reg <= info;
        end
    end

    bir_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .fetch (fetch),
        .x     (column),
        .y     (row_index),
        .cfg   (cfg),
        .info  (info),
        .x0    (x0),
        .y0    (y0)
    );

    // bank b = {row parity, column parity}
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [XW-1:0] rx;
        logic [YW-1:0] ry;
        logic [XW-1:0] xa;
        logic [YW-1:0] ya;
        assign xa = x0 + XW'(1);
        assign ya = y0 + YW'(1);
        assign rx = (x0[0] == b[0]) ? x0 : xa;
        assign ry = (y0[0] == b[1]) ? y0 : ya;
        bir_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_ram (
            .clk   (clk),
            .we    (ld_v_reg[1] && ld_x_reg[1][0] == b[0] && ld_y_reg[1][0] == b[1]),
            .waddr ({ld_y_reg[1][YW-1:1], ld_x_reg[1][XW-1:1]}),
            .wdata (ld_d_reg[1]),
            .raddr ({ry[YW-1:1], rx[XW-1:1]}),
            .rdata (rd[b])
        );
    end

    always_comb
    begin
        q00 = rd[{sel_reg[1], sel_reg[0]}];
        q01 = rd[{sel_reg[1], ~sel_reg[0]}];
        q10 = rd[{~sel_reg[1], sel_reg[0]}];
        q11 = rd[{~sel_reg[1], ~sel_reg[0]}];
    end

    bir_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .info     (info_reg),
        .p00      (q00),
        .p01      (q01),
        .p10      (q10),
        .p11      (q11),
        .bg_level (bgl_reg),
        .strobe   (done),
        .pixel    (rotated_pixel),
        .is_bg    (is_background)
    );

    `BIR_ASSERT_IMPL(a_bg_not_copy_pix, done && is_background,
        rotated_pixel[31:24] == 8'hFF)
    `BIR_ASSERT_NEXT(a_load_no_result, accept && operation == OP_LOAD && !info.valid,
        !info_reg.valid)
    `BIR_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
endmodule
`default_nettype wire

>>> test/bilinear_image_rotate_test.sv
// ----------------------------------------------------------------------------
// Bilinear image rotate testbench
// Loads source pixels and fetches rotated pixels under a series of register
// settings. Each fetch result is checked against a local bilinear predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bilinear_image_rotate_test;
    import bir_pkg::*;

    typedef struct {
        op_t         op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] pix;
    } item_t;

    typedef struct {
        logic [31:0] pix;
        logic        bg;
    } rot_result_t;

    typedef enum int { MAP_BACKGROUND, MAP_COPY, MAP_BLEND } map_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        operation = 1'b0;
    logic [7:0]  column = '0;
    logic [7:0]  row_index = '0;
    logic [31:0] source_pixel = '0;
    logic        done;
    logic [31:0] rotated_pixel;
    logic        is_background;

    bilinear_image_rotate DUT (.*);

    always #4 clk = ~clk;

    item_t       pending_items[$];
    rot_result_t expected_pixels[$];
    logic [31:0] pixel_store [0:65535];
    bit          loaded [0:65535];

    int          cfg_w = 256, cfg_h = 256, cfg_s = 0, cfg_c = 16384, cfg_bg = 255;
    int          gap_limit = 0;
    int          gap_left = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          pushed = 0;

    function automatic map_kind_t map_point(input int x, input int y, output int x0,
                                            output int y0, output int fx, output int fy);
        longint w, h, u2, v2, sx, sy;
        w = (cfg_w == 0) ? 1 : (cfg_w > MAX_WIDTH ? MAX_WIDTH : cfg_w);
        h = (cfg_h == 0) ? 1 : (cfg_h > MAX_HEIGHT ? MAX_HEIGHT : cfg_h);
        x0 = x; y0 = y; fx = 0; fy = 0;
        if (x >= w || y >= h) return MAP_BACKGROUND;
        if (cfg_s == 0 && cfg_c == 16384) return MAP_COPY;
        u2 = 2 * x - (w - 1);
        v2 = 2 * y - (h - 1);
        sx = (w - 1) * 16384 + u2 * cfg_c - v2 * cfg_s;
        sy = (h - 1) * 16384 + u2 * cfg_s + v2 * cfg_c;
        x0 = int'(sx >>> POS_BITS);
        y0 = int'(sy >>> POS_BITS);
        fx = int'(sx[POS_BITS-1:0]) >> (POS_BITS - FRACTION_BITS);
        fy = int'(sy[POS_BITS-1:0]) >> (POS_BITS - FRACTION_BITS);
        if (x0 < 0 || y0 < 0 || x0 + 1 >= w || y0 + 1 >= h) return MAP_BACKGROUND;
        return MAP_BLEND;
    endfunction

    function automatic rot_result_t rotate_pixel(input int x, input int y);
        rot_result_t r;
        int x0, y0, fx, fy;
        logic [31:0] p [4];
        longint a, b, c, d, top, bot, val;
        map_kind_t k;
        k = map_point(x, y, x0, y0, fx, fy);
        r.bg = 1'b1;
        r.pix = {8'hFF, cfg_bg[7:0], cfg_bg[7:0], cfg_bg[7:0]};
        if (k == MAP_COPY)
        begin
            r.bg = 1'b0;
            r.pix = pixel_store[y * MAX_WIDTH + x];
        end
        else if (k == MAP_BLEND)
        begin
            r.bg = 1'b0;
            p[0] = pixel_store[y0 * MAX_WIDTH + x0];
            p[1] = pixel_store[y0 * MAX_WIDTH + x0 + 1];
            p[2] = pixel_store[(y0 + 1) * MAX_WIDTH + x0];
            p[3] = pixel_store[(y0 + 1) * MAX_WIDTH + x0 + 1];
            for (int ch = 0; ch < 4; ch++)
            begin
                a = p[0][ch*8 +: 8]; b = p[1][ch*8 +: 8];
                c = p[2][ch*8 +: 8]; d = p[3][ch*8 +: 8];
                top = a * (256 - fx) + b * fx;
                bot = c * (256 - fx) + d * fx;
                val = (top * (256 - fy) + bot * fy + 32768) >> 16;
                if (val > 255) val = 255;
                r.pix[ch*8 +: 8] = val[7:0];
            end
        end
        return r;
    endfunction

    task automatic push_load(input int x, input int y, input logic [31:0] pix);
        item_t it;
        it.op = OP_LOAD; it.x = x[7:0]; it.y = y[7:0]; it.pix = pix;
        loaded[y * MAX_WIDTH + x] = 1'b1;
        pending_items = {pending_items, it};
        pushed++;
    endtask

    // loads any unwritten source pixel the fetch would read, then the fetch
    task automatic push_fetch(input int x, input int y);
        item_t it;
        int x0, y0, fx, fy;
        map_kind_t k;
        k = map_point(x, y, x0, y0, fx, fy);
        if (k != MAP_BACKGROUND)
            for (int dy = 0; dy < (k == MAP_BLEND ? 2 : 1); dy++)
                for (int dx = 0; dx < (k == MAP_BLEND ? 2 : 1); dx++)
                    if (!loaded[(y0 + dy) * MAX_WIDTH + x0 + dx])
                        push_load(x0 + dx, y0 + dy, $urandom);
        it.op = OP_FETCH; it.x = x[7:0]; it.y = y[7:0]; it.pix = $urandom;
        pending_items = {pending_items, it};
        pushed++;
    endtask

    task automatic apb_write(input reg_idx_t idx, input int value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = value & 32'h1FF;
            REG_HEIGHT: cfg_h = value & 32'h1FF;
            REG_SINE:   cfg_s = int'(signed'(value[15:0]));
            REG_COSINE: cfg_c = int'(signed'(value[15:0]));
            REG_BACKGR: cfg_bg = value & 32'hFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_pixels.size() != 0 || start)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (operation == OP_LOAD)
                    pixel_store[int'(row_index) * MAX_WIDTH + int'(column)] <= source_pixel;
                else
                    expected_pixels = {expected_pixels, rotate_pixel(column, row_index)};
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    item_t it;
                    it = pending_items.pop_front();
                    start <= 1'b1;
                    operation <= it.op;
                    column <= it.x;
                    row_index <= it.y;
                    source_pixel <= it.pix;
                    gap_left <= (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %08h bg %0b", rotated_pixel, is_background);
            end
            else
            begin
                rot_result_t e;
                e = expected_pixels.pop_front();
                if (rotated_pixel !== e.pix || is_background !== e.bg)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %08h bg %0b, got %08h bg %0b",
                                 e.pix, e.bg, rotated_pixel, is_background);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int w, h, x, y, pick, stop;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // unrotated copy at reset settings, extreme corners and pixel values
        push_load(0, 0, 32'h0000_0000);
        push_load(255, 255, 32'hFFFF_FFFF);
        push_load(0, 255, 32'hAAAA_AAAA);
        push_load(255, 0, 32'h5555_5555);
        push_fetch(0, 0); push_fetch(255, 255); push_fetch(0, 255); push_fetch(255, 0);
        drain();

        // quarter turn on the full frame, background black
        apb_write(REG_SINE, 16384);
        apb_write(REG_COSINE, 0);
        apb_write(REG_BACKGR, 0);
        push_fetch(0, 0); push_fetch(255, 255); push_fetch(128, 128); push_fetch(0, 255);
        drain();

        // tiny images: outside image, outside inner area, one pixel wide
        apb_write(REG_WIDTH, 1);
        apb_write(REG_HEIGHT, 1);
        apb_write(REG_BACKGR, 255);
        push_fetch(0, 0); push_fetch(5, 0); push_fetch(0, 200);
        drain();
        apb_write(REG_SINE, 0);
        apb_write(REG_COSINE, 16384);
        push_fetch(0, 0); push_fetch(1, 0);
        drain();
        apb_write(REG_WIDTH, 4);
        apb_write(REG_HEIGHT, 3);
        apb_write(REG_SINE, 11585);
        apb_write(REG_COSINE, 11585);
        push_fetch(1, 1); push_fetch(2, 1); push_fetch(3, 2); push_fetch(0, 0);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            pick = $urandom_range(0, 9);
            w = (pick == 0) ? 256 : (pick == 1 ? 1 : $urandom_range(2, 16));
            pick = $urandom_range(0, 9);
            h = (pick == 0) ? 256 : (pick == 1 ? 1 : $urandom_range(2, 16));
            apb_write(REG_WIDTH, w);
            apb_write(REG_HEIGHT, h);
            case ($urandom_range(0, 6))
                0: begin apb_write(REG_SINE, 0);      apb_write(REG_COSINE, 16384);  end
                1: begin apb_write(REG_SINE, -16384); apb_write(REG_COSINE, 0);      end
                2: begin apb_write(REG_SINE, 0);      apb_write(REG_COSINE, -16384); end
                3: begin apb_write(REG_SINE, 6270);   apb_write(REG_COSINE, 15137);  end
                default:
                begin
                    apb_write(REG_SINE, int'($urandom_range(0, 32768)) - 16384);
                    apb_write(REG_COSINE, int'($urandom_range(0, 32768)) - 16384);
                end
            endcase
            pick = $urandom_range(0, 3);
            apb_write(REG_BACKGR, pick == 0 ? 0 : (pick == 1 ? 255 : $urandom_range(0, 255)));
            gap_limit = (phase % 3 == 0) ? 0 : 17;
            stop = pushed + 45;
            for (int n = 0; pushed < stop; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    push_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                else if (pick < 3)
                    push_fetch($urandom_range(0, 255), $urandom_range(0, 255));
                else
                begin
                    x = $urandom_range(0, (w > 256 ? 256 : w) - 1);
                    y = $urandom_range(0, (h > 256 ? 256 : h) - 1);
                    push_fetch(x, y);
                end
                // stop adding items until every result is back
                if (n == 20)
                    while (pending_items.size() != 0 || expected_pixels.size() != 0 || start)
                        @(posedge clk);
            end
            drain();
        end

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
